// ===== rtl/core/dmac_pkg.sv =====
`timescale 1ns / 1ps
package dmac_pkg;

  localparam int NUM_CH = 7;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_TICK  = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RK_READ   = 3'd0,
    RK_WRITE  = 3'd1,
    RK_GFX    = 3'd2,
    RK_DONE   = 3'd3,
    RK_IGNORE = 3'd4
  } kind_t;

  localparam logic [1:0] CFG_CH_EN  = 2'd0;
  localparam logic [1:0] CFG_IRQ_EN = 2'd1;
  localparam logic [1:0] CFG_MASTER = 2'd2;

  localparam logic [31:0] START_BIT = 32'h0100_0000;
  localparam logic [31:0] CW_BLOCK  = 32'h0100_0201;
  localparam logic [31:0] CW_CHAIN  = 32'h0100_0401;
  localparam logic [31:0] CW_TABLE  = 32'h1100_0002;
  localparam logic [23:0] END_LINK  = 24'hff_ffff;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  channel;
    logic [23:0] start_address;
    logic [15:0] block_size;
    logic [15:0] block_count;
    logic [31:0] control_word;
    logic [31:0] mem_data;
    logic [6:0]  ack_mask;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [20:0] mem_address;
    logic [31:0] data_word;
    logic [2:0]  done_channel;
    logic        irq_line;
    logic [6:0]  irq_flags;
    logic        master_flag;
    logic        last;
  } out_item_t;

  // Classified item handed from the front part to the sequencer.
  typedef enum logic [2:0] {
    CMD_IGNORE,
    CMD_DONE,
    CMD_BLOCK,
    CMD_CHAIN,
    CMD_TABLE,
    CMD_DATA,
    CMD_TICK,
    CMD_ACK
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [2:0]  channel;
    logic [23:0] address;
    logic [31:0] words;
    logic [15:0] entries;
    logic [31:0] data;
    logic [6:0]  ack_mask;
  } job_t;

endpackage

// ===== rtl/core/dmac_front.sv =====
`timescale 1ns / 1ps
module dmac_front import dmac_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     job_ready,
  output logic     job_valid,
  output job_t     job
);

  logic [31:0] prod_r;
  job_t        job_r;
  logic        valid_r;
  logic        prod_sel_r;
  job_t        job_nxt;

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;

  always_comb begin
    job_nxt = '0;
    job_nxt.channel  = in_item.channel;
    job_nxt.address  = in_item.start_address;
    job_nxt.entries  = in_item.block_count;
    job_nxt.data     = in_item.mem_data;
    job_nxt.ack_mask = in_item.ack_mask;
    case (op_t'(in_item.operation))
      OP_START: begin
        if (in_item.control_word[24] == 1'b0) begin
          job_nxt.cmd = CMD_IGNORE;
        end else if (in_item.channel == 3'd2 && in_item.control_word == CW_BLOCK) begin
          job_nxt.cmd = CMD_BLOCK;
        end else if (in_item.channel == 3'd2 && in_item.control_word == CW_CHAIN) begin
          job_nxt.cmd = CMD_CHAIN;
        end else if (in_item.channel == 3'd6 && in_item.control_word == CW_TABLE) begin
          job_nxt.cmd = CMD_TABLE;
        end else begin
          job_nxt.cmd = CMD_DONE;
        end
      end
      OP_DATA: job_nxt.cmd = CMD_DATA;
      OP_TICK: job_nxt.cmd = CMD_TICK;
      default: job_nxt.cmd = CMD_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      job_r      <= job_nxt;
      prod_r     <= 32'(in_item.block_size) * 32'(in_item.block_count);
      prod_sel_r <= (job_nxt.cmd == CMD_BLOCK);
    end
  end

  always_comb begin
    job = job_r;
    if (prod_sel_r) begin
      job.words = prod_r;
    end
  end

endmodule

// ===== rtl/core/dmac_back.sv =====
`timescale 1ns / 1ps
module dmac_back import dmac_pkg::*; #(
  parameter int ADDR_BITS = 21
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_ready,
  input  job_t      job,
  input  logic [6:0] ch_en,
  input  logic [6:0] irq_en,
  input  logic      master_en,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_BLOCK = 2'd1;
  localparam logic [1:0] MODE_CHAIN = 2'd2;
  localparam logic [1:0] MODE_TABLE = 2'd3;

  logic                 busy_r, busy_nxt;
  logic [2:0]           act_ch_r, act_ch_nxt;
  logic [1:0]           mode_r, mode_nxt;
  logic                 phase_r, phase_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [31:0]          left_r, left_nxt;
  logic [23:0]          link_r, link_nxt;
  logic [15:0]          tleft_r, tleft_nxt;
  logic [6:0]           flags_r, flags_nxt;
  logic                 master_r, master_nxt;
  logic                 irq_r, irq_nxt;

  // Up to two results per item; slot 1 is held when two are produced.
  out_item_t            o0_r, o1_r;
  logic                 v0_r, v1_r;
  out_item_t            r0, r1;
  logic                 n0, n1;
  logic                 take;
  logic [ADDR_BITS-1:0] addr_p4, addr_m4;
  logic [6:0]           fset;

  assign addr_p4   = addr_r + ADDR_BITS'(4);
  assign addr_m4   = addr_r - ADDR_BITS'(4);
  assign out_valid = v0_r;
  assign out_item  = o0_r;
  assign job_ready = !v0_r || (out_ready && !v1_r);
  assign take      = job_valid && job_ready;

  always_comb begin
    busy_nxt = busy_r; act_ch_nxt = act_ch_r; mode_nxt = mode_r;
    phase_nxt = phase_r; addr_nxt = addr_r; left_nxt = left_r;
    link_nxt = link_r; tleft_nxt = tleft_r; flags_nxt = flags_r;
    master_nxt = master_r; irq_nxt = irq_r;
    r0 = '0; r1 = '0; n0 = 1'b0; n1 = 1'b0; fset = '0;
    r0.done_channel = act_ch_r;
    r1.done_channel = act_ch_r;
    r1.result_kind  = RK_DONE;
    case (job.cmd)
      CMD_IGNORE, CMD_DONE, CMD_BLOCK, CMD_CHAIN, CMD_TABLE: begin
        n0 = 1'b1;
        r0.done_channel = job.channel;
        if (busy_r || job.channel == 3'd7 || !ch_en[job.channel]
            || job.cmd == CMD_IGNORE) begin
          r0.result_kind = RK_IGNORE;
        end else begin
          act_ch_nxt = job.channel;
          addr_nxt   = job.address[ADDR_BITS-1:0];
          r0.result_kind = RK_DONE;
          if (job.cmd == CMD_BLOCK && job.words != '0) begin
            left_nxt = job.words; busy_nxt = 1'b1; mode_nxt = MODE_BLOCK;
            r0.result_kind = RK_READ;
            r0.mem_address = 21'(job.address[ADDR_BITS-1:0]);
          end else if (job.cmd == CMD_CHAIN) begin
            busy_nxt = 1'b1; mode_nxt = MODE_CHAIN; phase_nxt = 1'b0;
            r0.result_kind = RK_READ;
            r0.mem_address = 21'(job.address[ADDR_BITS-1:0]);
          end else if (job.cmd == CMD_TABLE) begin
            tleft_nxt = job.entries;
            if (job.entries != '0) begin
              busy_nxt = 1'b1; mode_nxt = MODE_TABLE; n0 = 1'b0;
            end else begin
              fset = 7'(1) << job.channel;
            end
          end else begin
            fset = 7'(1) << job.channel;
          end
        end
      end
      CMD_DATA: begin
        if (busy_r && mode_r == MODE_BLOCK) begin
          n0 = 1'b1; n1 = 1'b1;
          r0.result_kind = RK_GFX; r0.data_word = job.data;
          left_nxt = left_r - 32'd1;
          addr_nxt = addr_p4;
          if (left_r == 32'd1) begin
            fset = 7'(1) << act_ch_r;
          end else begin
            r1.result_kind = RK_READ; r1.mem_address = 21'(addr_p4);
          end
        end else if (busy_r && mode_r == MODE_CHAIN) begin
          if (!phase_r) begin
            left_nxt = {24'd0, job.data[31:24]};
            link_nxt = job.data[23:0];
            n0 = 1'b1;
            if (job.data[31:24] == 8'd0) begin
              if (job.data[23:0] == END_LINK) begin
                r0.result_kind = RK_DONE; fset = 7'(1) << act_ch_r;
              end else begin
                addr_nxt = job.data[ADDR_BITS-1:0];
                r0.result_kind = RK_READ;
                r0.mem_address = 21'(job.data[ADDR_BITS-1:0]);
              end
            end else begin
              phase_nxt = 1'b1; addr_nxt = addr_p4;
              r0.result_kind = RK_READ; r0.mem_address = 21'(addr_p4);
            end
          end else begin
            n0 = 1'b1; n1 = 1'b1;
            r0.result_kind = RK_GFX; r0.data_word = job.data;
            left_nxt = left_r - 32'd1;
            if (left_r == 32'd1) begin
              if (link_r == END_LINK) begin
                fset = 7'(1) << act_ch_r;
              end else begin
                addr_nxt = link_r[ADDR_BITS-1:0]; phase_nxt = 1'b0;
                r1.result_kind = RK_READ;
                r1.mem_address = 21'(link_r[ADDR_BITS-1:0]);
              end
            end else begin
              addr_nxt = addr_p4;
              r1.result_kind = RK_READ; r1.mem_address = 21'(addr_p4);
            end
          end
        end
      end
      CMD_TICK: begin
        if (busy_r && mode_r == MODE_TABLE) begin
          n0 = 1'b1;
          r0.result_kind = RK_WRITE; r0.mem_address = 21'(addr_r);
          if (tleft_r <= 16'd1) begin
            n1 = 1'b1; tleft_nxt = '0;
            r0.data_word = {8'd0, END_LINK};
            fset = 7'(1) << act_ch_r;
          end else begin
            r0.data_word = {8'd0, 24'(addr_r) - 24'd4};
            tleft_nxt = tleft_r - 16'd1;
            addr_nxt = addr_m4;
          end
        end
      end
      default: begin
        flags_nxt = flags_r & ~job.ack_mask;
      end
    endcase
    if (fset != '0) begin
      flags_nxt = flags_r | fset;
      if (master_en && (flags_nxt & irq_en) != '0) begin
        master_nxt = 1'b1; irq_nxt = 1'b1;
      end else begin
        irq_nxt = 1'b0;
      end
      flags_nxt  = flags_nxt & irq_en;
      master_nxt = master_nxt & master_en;
      busy_nxt = 1'b0; mode_nxt = MODE_NONE; phase_nxt = 1'b0;
    end
    r0.irq_line = irq_nxt; r0.irq_flags = flags_nxt; r0.master_flag = master_nxt;
    r1.irq_line = irq_nxt; r1.irq_flags = flags_nxt; r1.master_flag = master_nxt;
    r0.last = !n1;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; act_ch_r <= '0; mode_r <= MODE_NONE; phase_r <= 1'b0;
      addr_r <= '0; left_r <= '0; link_r <= '0; tleft_r <= '0;
      flags_r <= '0; master_r <= 1'b0; irq_r <= 1'b0;
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else begin
      if (take) begin
        busy_r <= busy_nxt; act_ch_r <= act_ch_nxt; mode_r <= mode_nxt;
        phase_r <= phase_nxt; addr_r <= addr_nxt; left_r <= left_nxt;
        link_r <= link_nxt; tleft_r <= tleft_nxt; flags_r <= flags_nxt;
        master_r <= master_nxt; irq_r <= irq_nxt;
      end
      if (take && n0) begin
        v0_r <= 1'b1;
        o0_r <= r0;
        v1_r <= n1;
        o1_r <= r1;
      end else if (v0_r && out_ready) begin
        v0_r <= v1_r;
        o0_r <= o1_r;
        v1_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/dma_channel_controller.sv =====
`timescale 1ns / 1ps
// Timing: an accepted item is registered in the front part (job_r), and its
// first result is registered in the back part's output slot (o0_r).
// Throughput: one item per cycle while out_ready is high; an item with two
// results holds the input while the second result drains.
// Reset: synchronous active-low rst_n clears all transfer, flag and
// configuration state.
module dma_channel_controller import dmac_pkg::*; #(
  parameter int ADDR_BITS = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  logic [6:0] ch_en_r, irq_en_r;
  logic       master_en_r;
  logic       q_valid, q_ready;
  job_t       q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_en_r <= '0; irq_en_r <= '0; master_en_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CH_EN:  ch_en_r <= cfg_data;
        CFG_IRQ_EN: irq_en_r <= cfg_data;
        CFG_MASTER: master_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  dmac_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .job_ready(q_ready), .job_valid(q_valid), .job(q_job)
  );

  dmac_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job_ready(q_ready),
    .job(q_job), .ch_en(ch_en_r), .irq_en(irq_en_r), .master_en(master_en_r),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while waiting");
  a_master: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.irq_line |-> out_item.master_flag)
    else $error("irq without master flag");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.result_kind <= RK_IGNORE)
    else $error("bad result kind");
`endif

endmodule

// ===== test/dmac_checker.sv =====
`timescale 1ns / 1ps
module dmac_checker import dmac_pkg::*; #(
  parameter int ADDR_BITS = 21
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         fail_count,
  output int         pending,
  output logic       xfer_busy,
  output logic       table_mode
);

  typedef enum logic [1:0] {
    XF_NONE  = 2'd0,
    XF_BLOCK = 2'd1,
    XF_CHAIN = 2'd2,
    XF_TABLE = 2'd3
  } xfer_t;

  out_item_t expected_q[$];
  out_item_t batch[$];
  int fails;

  logic [6:0] ch_en, irq_en;
  logic master_en;
  logic busy;
  logic [2:0] act_ch;
  xfer_t mode;
  logic in_payload;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [31:0] words_left;
  logic [23:0] next_link;
  logic [15:0] table_left;
  logic [6:0] flags;
  logic master, irq;

  assign fail_count = fails;
  assign pending = expected_q.size();
  assign xfer_busy = busy;
  assign table_mode = (mode == XF_TABLE);

  initial fails = 0;

  task automatic emit(kind_t k, logic [ADDR_BITS-1:0] a, logic [31:0] d, logic [2:0] ch);
    out_item_t r;
    r = '0;
    r.result_kind = k;
    r.mem_address = 21'(a);
    r.data_word = d;
    r.done_channel = ch;
    batch.push_back(r);
  endtask

  task automatic finish_xfer(logic [2:0] ch);
    flags = (flags | (7'd1 << ch));
    if (master_en && ((flags & irq_en) != 0)) begin
      master = 1'b1;
      irq = 1'b1;
    end else begin
      irq = 1'b0;
    end
    flags &= irq_en;
    master &= master_en;
    busy = 1'b0;
    mode = XF_NONE;
    in_payload = 1'b0;
    emit(RK_DONE, '0, '0, ch);
  endtask

  task automatic follow_link();
    if (next_link == END_LINK) begin
      finish_xfer(act_ch);
    end else begin
      cur_addr = ADDR_BITS'(next_link);
      in_payload = 1'b0;
      emit(RK_READ, cur_addr, '0, act_ch);
    end
  endtask

  task automatic predict_item(in_item_t it);
    out_item_t r;
    batch.delete();
    case (op_t'(it.operation))
      OP_START: begin
        if (busy || it.channel == 3'd7 || !ch_en[it.channel] ||
            (it.control_word & START_BIT) == 0) begin
          emit(RK_IGNORE, '0, '0, it.channel);
        end else begin
          act_ch = it.channel;
          cur_addr = ADDR_BITS'(it.start_address);
          if (it.channel == 3'd2 && it.control_word == CW_BLOCK) begin
            words_left = 32'(it.block_size) * 32'(it.block_count);
            if (words_left == 0) begin
              finish_xfer(it.channel);
            end else begin
              busy = 1'b1;
              mode = XF_BLOCK;
              emit(RK_READ, cur_addr, '0, it.channel);
            end
          end else if (it.channel == 3'd2 && it.control_word == CW_CHAIN) begin
            busy = 1'b1;
            mode = XF_CHAIN;
            in_payload = 1'b0;
            emit(RK_READ, cur_addr, '0, it.channel);
          end else if (it.channel == 3'd6 && it.control_word == CW_TABLE) begin
            table_left = it.block_count;
            if (table_left == 0) begin
              finish_xfer(it.channel);
            end else begin
              busy = 1'b1;
              mode = XF_TABLE;
            end
          end else begin
            finish_xfer(it.channel);
          end
        end
      end
      OP_DATA: begin
        if (busy && mode == XF_BLOCK) begin
          emit(RK_GFX, '0, it.mem_data, act_ch);
          words_left--;
          cur_addr = cur_addr + 4;
          if (words_left == 0) finish_xfer(act_ch);
          else emit(RK_READ, cur_addr, '0, act_ch);
        end else if (busy && mode == XF_CHAIN) begin
          if (!in_payload) begin
            words_left = 32'(it.mem_data[31:24]);
            next_link = it.mem_data[23:0];
            if (words_left == 0) begin
              follow_link();
            end else begin
              in_payload = 1'b1;
              cur_addr = cur_addr + 4;
              emit(RK_READ, cur_addr, '0, act_ch);
            end
          end else begin
            emit(RK_GFX, '0, it.mem_data, act_ch);
            words_left--;
            if (words_left == 0) begin
              follow_link();
            end else begin
              cur_addr = cur_addr + 4;
              emit(RK_READ, cur_addr, '0, act_ch);
            end
          end
        end
      end
      OP_TICK: begin
        if (busy && mode == XF_TABLE) begin
          if (table_left <= 1) begin
            emit(RK_WRITE, cur_addr, 32'(END_LINK), act_ch);
            table_left = '0;
            finish_xfer(act_ch);
          end else begin
            emit(RK_WRITE, cur_addr, {8'd0, 24'(cur_addr) - 24'd4}, act_ch);
            table_left--;
            cur_addr = cur_addr - 4;
          end
        end
      end
      default: flags &= ~it.ack_mask;
    endcase
    foreach (batch[k]) begin
      r = batch[k];
      r.irq_line = irq;
      r.irq_flags = flags;
      r.master_flag = master;
      r.last = (k == batch.size() - 1);
      expected_q.push_back(r);
    end
  endtask

  task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", nm, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      ch_en = '0; irq_en = '0; master_en = 1'b0;
      busy = 1'b0; act_ch = '0; mode = XF_NONE; in_payload = 1'b0;
      cur_addr = '0; words_left = '0; next_link = '0; table_left = '0;
      flags = '0; master = 1'b0; irq = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CH_EN: ch_en = cfg_data;
          CFG_IRQ_EN: irq_en = cfg_data;
          CFG_MASTER: master_en = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item: %p", out_item);
          fails++;
        end else begin
          e = expected_q.pop_front();
          chk("result_kind", 32'(e.result_kind), 32'(out_item.result_kind));
          chk("mem_address", 32'(e.mem_address), 32'(out_item.mem_address));
          chk("data_word", e.data_word, out_item.data_word);
          chk("done_channel", 32'(e.done_channel), 32'(out_item.done_channel));
          chk("irq_line", 32'(e.irq_line), 32'(out_item.irq_line));
          chk("irq_flags", 32'(e.irq_flags), 32'(out_item.irq_flags));
          chk("master_flag", 32'(e.master_flag), 32'(out_item.master_flag));
          chk("last", 32'(e.last), 32'(out_item.last));
        end
      end
      if (in_valid && in_ready) predict_item(in_item);
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import dmac_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 275;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_item_t in_item;
  out_item_t out_item;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  int fails, pending;
  logic xfer_busy, table_mode;

  int sent = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  dma_channel_controller DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dmac_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fails), .pending(pending),
    .xfer_busy(xfer_busy), .table_mode(table_mode)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dma_channel_controller verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic in_item_t rnd_item();
    in_item_t it;
    it.operation = 2'($urandom);
    it.channel = 3'($urandom);
    it.start_address = 24'($urandom);
    it.block_size = 16'($urandom);
    it.block_count = 16'($urandom);
    it.control_word = $urandom;
    it.mem_data = $urandom;
    it.ack_mask = 7'($urandom);
    return it;
  endfunction

  function automatic in_item_t op_item(op_t op);
    in_item_t it;
    it = rnd_item();
    it.operation = op;
    return it;
  endfunction

  function automatic in_item_t start_item(logic [2:0] ch, logic [31:0] cw,
                                         logic [23:0] a, logic [15:0] bs,
                                         logic [15:0] bc);
    in_item_t it;
    it = op_item(OP_START);
    it.channel = ch;
    it.control_word = cw;
    it.start_address = a;
    it.block_size = bs;
    it.block_count = bc;
    return it;
  endfunction

  function automatic in_item_t data_item(logic [31:0] d);
    in_item_t it;
    it = op_item(OP_DATA);
    it.mem_data = d;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance,
  // with in_valid still high, so the caller must send again or go quiet.
  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic quiet();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic flush_xfer();
    while (xfer_busy) begin
      if (table_mode) send(op_item(OP_TICK));
      else send(data_item({8'd0, END_LINK}));
    end
  endtask

  task automatic drain();
    flush_xfer();
    quiet();
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic block_seq(int bs, int bc, logic [23:0] a);
    send(start_item(3'd2, CW_BLOCK, a, 16'(bs), 16'(bc)));
    repeat (bs * bc) send(data_item($urandom));
  endtask

  task automatic chain_seq(int hops);
    int len;
    send(start_item(3'd2, CW_CHAIN, 24'($urandom), 16'($urandom), 16'($urandom)));
    for (int h = 0; h < hops; h++) begin
      len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 3);
      send(data_item({8'(len), (h == hops - 1) ? END_LINK : 24'($urandom)}));
      repeat (len) send(data_item($urandom));
    end
  endtask

  task automatic table_seq(int n, logic [23:0] a);
    send(start_item(3'd6, CW_TABLE, a, 16'($urandom), 16'(n)));
    repeat (n) send(op_item(OP_TICK));
  endtask

  task automatic directed();
    send(start_item(3'd0, START_BIT, 24'hff_ffff, 16'hffff, 16'hffff));
    send(start_item(3'd7, 32'hffff_ffff, 24'h0, 16'h0, 16'h0));
    send(start_item(3'd1, 32'h0, 24'h12_3456, 16'h1, 16'h1));
    send(start_item(3'd3, 32'hffff_ffff, 24'hff_ffff, 16'hffff, 16'hffff));
    block_seq(1, 2, 24'h1f_fffc);
    send(start_item(3'd2, CW_BLOCK, 24'h00_0100, 16'd1, 16'd1));
    send(start_item(3'd0, START_BIT, 24'h0, 16'h0, 16'h0));
    send(data_item(32'hffff_ffff));
    send(start_item(3'd2, CW_BLOCK, 24'h00_0040, 16'hffff, 16'h0));
    send(start_item(3'd2, CW_CHAIN, 24'h00_0200, 16'h0, 16'h0));
    send(data_item(32'h0000_0300));
    send(data_item({8'd2, END_LINK}));
    send(data_item(32'h0));
    send(data_item(32'hffff_ffff));
    send(start_item(3'd2, CW_CHAIN, 24'h00_0010, 16'h0, 16'h0));
    send(data_item({8'd0, END_LINK}));
    table_seq(0, 24'h00_1000);
    table_seq(3, 24'h00_0004);
    send(data_item(32'h5a5a_a5a5));
    send(op_item(OP_TICK));
    send(start_item(3'd5, START_BIT, 24'h0, 16'h0, 16'h0));
    send(start_item(3'd6, START_BIT, 24'h0, 16'h0, 16'h0));
    send(op_item(OP_ACK));
  endtask

  initial begin
    int target;
    int pick;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CH_EN;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          idle_pct = 0; stall_pct = 0;
          cfg_write(CFG_CH_EN, 7'h7f);
          cfg_write(CFG_IRQ_EN, 7'h7f);
          cfg_write(CFG_MASTER, 7'd1);
        end
        1: begin
          idle_pct = 46; stall_pct = 0;
          cfg_write(CFG_CH_EN, 7'h00);
          cfg_write(CFG_IRQ_EN, 7'h00);
          cfg_write(CFG_MASTER, 7'd0);
        end
        2: begin
          idle_pct = 0; stall_pct = 46;
          cfg_write(CFG_CH_EN, 7'($urandom) | 7'h44);
          cfg_write(CFG_IRQ_EN, 7'($urandom));
          cfg_write(CFG_MASTER, 7'd1);
        end
        3: begin
          idle_pct = 35; stall_pct = 35;
          cfg_write(CFG_CH_EN, 7'h7f);
          cfg_write(CFG_IRQ_EN, 7'($urandom));
          cfg_write(CFG_MASTER, 7'd0);
        end
        default: begin
          idle_pct = (p == 4) ? 46 : 0;
          stall_pct = (p == 4) ? 46 : 0;
          cfg_write(CFG_CH_EN, 7'($urandom) | (($urandom_range(4) != 0) ? 7'h44 : 7'h0));
          cfg_write(CFG_IRQ_EN, 7'($urandom));
          cfg_write(CFG_MASTER, 7'($urandom_range(1)));
        end
      endcase

      if (p == 0) begin
        directed();
        hold_cycles = 300;
        repeat (40) send(start_item(3'd0, START_BIT, 24'($urandom), 16'($urandom),
                                    16'($urandom)));
      end

      target = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        pick = $urandom_range(9);
        case (pick)
          0, 1, 2: block_seq($urandom_range(0, 4), $urandom_range(0, 3), 24'($urandom));
          3, 4, 5: chain_seq($urandom_range(1, 3));
          6, 7: table_seq($urandom_range(0, 5),
                          $urandom_range(1) ? 24'($urandom_range(0, 12)) : 24'($urandom));
          8: repeat ($urandom_range(1, 4)) send(rnd_item());
          default: begin
            send(start_item(3'd2, $urandom_range(1) ? CW_CHAIN : CW_BLOCK,
                            24'($urandom), 16'($urandom_range(1, 3)), 16'($urandom_range(1, 3))));
            repeat ($urandom_range(0, 2)) send(rnd_item());
            flush_xfer();
          end
        endcase
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("dma_channel_controller verification clean");
    end else begin
      $display("dma_channel_controller verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dmac_pkg.sv
rtl/core/dmac_front.sv
rtl/core/dmac_back.sv
rtl/core/dma_channel_controller.sv
test/dmac_checker.sv
test/tb.sv
